FILE: design/lcwc_pkg.sv
package lcwc_pkg;

  // Field and register widths
  localparam int ADC_BITS   = 24;
  localparam int WEIGHT_W   = 32;
  localparam int CAL_W      = ADC_BITS + WEIGHT_W;
  localparam int CAL_POINTS = 4;
  localparam int SEGMENTS   = CAL_POINTS - 1;
  localparam int SEG_IDX_W  = $clog2(CAL_POINTS);
  localparam int ALPHA_W    = 16;
  localparam int THR_W      = 31;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CAL_W;

  // Timeout streak
  localparam int FAIL_LIMIT = 3;
  localparam int FAIL_W     = $clog2(FAIL_LIMIT + 1);

  // Internal arithmetic widths
  localparam int DIFF_W    = WEIGHT_W + 1;
  localparam int SUM_W     = WEIGHT_W + 2;
  localparam int PROD_W    = CAL_W;
  localparam int MUL_A_W   = DIFF_W;
  localparam int MUL_B_W   = WEIGHT_W;
  localparam int DIV_CNT_W = $clog2(WEIGHT_W);

  // Register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_FAST_RST = ALPHA_W'(32768);
  localparam logic [ALPHA_W-1:0] ALPHA_SLOW_RST = ALPHA_W'(6554);
  localparam logic [THR_W-1:0]   BIG_DELTA_RST  = THR_W'(10240);
  localparam logic [THR_W-1:0]   DEADBAND_RST   = THR_W'(51);

  typedef logic signed [ADC_BITS-1:0] adc_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  localparam weight_t WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam weight_t WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE      = 3'd0,
    OP_TIMEOUT     = 3'd1,
    OP_TARE_REQ    = 3'd2,
    OP_TARE_CLR    = 3'd3,
    OP_REINIT_DONE = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_0      = 3'd0,
    REG_CAL_1      = 3'd1,
    REG_CAL_2      = 3'd2,
    REG_CAL_3      = 3'd3,
    REG_ALPHA_FAST = 3'd4,
    REG_ALPHA_SLOW = 3'd5,
    REG_BIG_DELTA  = 3'd6,
    REG_DEADBAND   = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEG,
    ST_PREP,
    ST_CAL_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_INTERP,
    ST_TARE,
    ST_OFFSET,
    ST_SM_DIFF,
    ST_SM_ALPHA,
    ST_SM_MUL,
    ST_SM_ADD,
    ST_DB_DIFF,
    ST_DB_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CAL_POINTS-1:0][CAL_W-1:0] cal_point;
    logic [ALPHA_W-1:0]               alpha_fast;
    logic [ALPHA_W-1:0]               alpha_slow;
    logic [THR_W-1:0]                 big_delta;
    logic [THR_W-1:0]                 deadband;
  } cfg_t;

  // Calibration point unpacking
  function automatic adc_t point_raw(input logic [CAL_W-1:0] p);
    return p[ADC_BITS-1:0];
  endfunction

  function automatic weight_t point_wt(input logic [CAL_W-1:0] p);
    return p[CAL_W-1:ADC_BITS];
  endfunction

  // Clamp a widened sum back into the weight range
  function automatic weight_t sat_weight(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-WEIGHT_W:0] top;
    top = v[SUM_W-1:WEIGHT_W-1];
    if (!v[SUM_W-1] && (|top)) begin
      return WEIGHT_MAX;
    end else if (v[SUM_W-1] && !(&top)) begin
      return WEIGHT_MIN;
    end else begin
      return v[WEIGHT_W-1:0];
    end
  endfunction

endpackage

FILE: design/lcwc_ifs.sv
// Command channel: op code and ADC sample
interface lcwc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [lcwc_pkg::OP_W-1:0]           op;
  logic signed [lcwc_pkg::ADC_BITS-1:0] raw_sample;

  modport source(output valid, op, raw_sample, input ready);
  modport sink(input valid, op, raw_sample, output ready);
endinterface

// Result channel: one item per command
interface lcwc_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 weight_valid;
  logic signed [lcwc_pkg::WEIGHT_W-1:0] display_weight;
  logic                                 reinit_request;
  logic signed [lcwc_pkg::WEIGHT_W-1:0] tare_offset_out;

  modport source(output valid, weight_valid, display_weight, reinit_request, tare_offset_out,
                 input ready);
  modport sink(input valid, weight_valid, display_weight, reinit_request, tare_offset_out,
               output ready);
endinterface

FILE: design/lcwc_cfg.sv
module lcwc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lcwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcwc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output lcwc_pkg::cfg_t                   cfg
);

  // Register file with write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_point  <= '0;
      cfg.alpha_fast <= lcwc_pkg::ALPHA_FAST_RST;
      cfg.alpha_slow <= lcwc_pkg::ALPHA_SLOW_RST;
      cfg.big_delta  <= lcwc_pkg::BIG_DELTA_RST;
      cfg.deadband   <= lcwc_pkg::DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        lcwc_pkg::REG_CAL_0, lcwc_pkg::REG_CAL_1,
        lcwc_pkg::REG_CAL_2, lcwc_pkg::REG_CAL_3: begin
          cfg.cal_point[cfg_index[lcwc_pkg::SEG_IDX_W-1:0]] <=
            cfg_wdata[lcwc_pkg::CAL_W-1:0];
        end
        lcwc_pkg::REG_ALPHA_FAST: begin
          cfg.alpha_fast <= cfg_wdata[lcwc_pkg::ALPHA_W-1:0];
        end
        lcwc_pkg::REG_ALPHA_SLOW: begin
          cfg.alpha_slow <= cfg_wdata[lcwc_pkg::ALPHA_W-1:0];
        end
        lcwc_pkg::REG_BIG_DELTA: begin
          cfg.big_delta <= cfg_wdata[lcwc_pkg::THR_W-1:0];
        end
        lcwc_pkg::REG_DEADBAND: begin
          cfg.deadband <= cfg_wdata[lcwc_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/lcwc_div.sv
module lcwc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lcwc_pkg::PROD_W-1:0]      dividend,
  input  logic [lcwc_pkg::ADC_BITS-1:0]    divisor,
  output logic                             done,
  output logic [lcwc_pkg::WEIGHT_W-1:0]    quotient
);

  // Restoring divider, one quotient bit per cycle. The caller guarantees
  // the quotient fits WEIGHT_W bits, so the upper dividend bits start as
  // the partial remainder.
  logic                                 busy;
  logic [lcwc_pkg::DIV_CNT_W-1:0]       cnt;
  logic [lcwc_pkg::ADC_BITS-1:0]        rem;
  logic [lcwc_pkg::ADC_BITS-1:0]        dvs;
  logic [lcwc_pkg::ADC_BITS+1:0]        trial;
  logic [lcwc_pkg::ADC_BITS:0]          shifted;
  logic                                 borrow;

  assign shifted  = {rem, quotient[lcwc_pkg::WEIGHT_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dvs};
  assign borrow   = trial[lcwc_pkg::ADC_BITS+1];

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= lcwc_pkg::DIV_CNT_W'(lcwc_pkg::WEIGHT_W - 1);
      end else if (busy) begin
        cnt <= cnt - lcwc_pkg::DIV_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[lcwc_pkg::PROD_W-1:lcwc_pkg::WEIGHT_W];
      quotient <= dividend[lcwc_pkg::WEIGHT_W-1:0];
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= borrow ? shifted[lcwc_pkg::ADC_BITS-1:0] : trial[lcwc_pkg::ADC_BITS-1:0];
      quotient <= {quotient[lcwc_pkg::WEIGHT_W-2:0], ~borrow};
    end
  end

endmodule

FILE: design/load_cell_weight_conditioner.sv
// Channel  Role    Handshake      Payload
// cmd      sink    valid/ready    op, raw_sample
// result   source  valid/ready    weight_valid, display_weight, reinit_request,
//                                 tare_offset_out
// cfg      write   cfg_we         cfg_index, cfg_wdata
//
// A sample passes segment search, operand setup, calibration multiply and the
// bit-serial divider of the interpolation, then tare, offset, filter and
// deadband. A sample clamped to an end point or on a zero-width segment skips
// the divider. An empty filter skips smoothing, an empty deadband the compare.
// Other ops go from decode to the result load. One item is in work at a time.
// Reset (rst, synchronous) restores register defaults and empties all state.
// A result waits in the output register; the next item is accepted meanwhile.
// While the output register stays full the sequencer holds in its last state.
module load_cell_weight_conditioner (
  input  logic                             clk,
  input  logic                             rst,
  lcwc_cmd_if.sink                         cmd,
  lcwc_res_if.source                       result,
  input  logic                             cfg_we,
  input  logic [lcwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcwc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  lcwc_pkg::cfg_t   cfg;
  lcwc_pkg::state_t state, state_next;

  // Item registers
  logic [lcwc_pkg::OP_W-1:0]       op_code;
  lcwc_pkg::adc_t                  raw;
  logic [lcwc_pkg::SEG_IDX_W-1:0]  seg;
  lcwc_pkg::weight_t               weight;
  logic [lcwc_pkg::ADC_BITS-1:0]   num;
  logic [lcwc_pkg::ADC_BITS-1:0]   den;
  logic [lcwc_pkg::WEIGHT_W-1:0]   mag;
  logic                            dw_neg;
  logic [lcwc_pkg::PROD_W-1:0]     prod;
  lcwc_pkg::weight_t               tared;
  logic                            sm_neg;
  logic [lcwc_pkg::DIFF_W-1:0]     delta;
  logic [lcwc_pkg::ALPHA_W-1:0]    alpha;
  logic [lcwc_pkg::DIFF_W-1:0]     db_mag;

  // Architectural state
  logic                            tare_pending;
  lcwc_pkg::weight_t               tare_offset;
  lcwc_pkg::weight_t               smooth_value;
  logic                            smooth_valid;
  lcwc_pkg::weight_t               shown_value;
  logic                            shown_valid;
  logic [lcwc_pkg::FAIL_W-1:0]     fail_streak;

  // Output register
  logic                            res_valid;
  logic                            res_weight_valid;
  lcwc_pkg::weight_t               res_display;
  logic                            res_reinit;
  lcwc_pkg::weight_t               res_tare;

  // Control outputs of the sequencer
  logic                            accept;
  logic                            div_start;
  logic                            out_load;
  logic [lcwc_pkg::MUL_A_W-1:0]    mul_a;
  logic [lcwc_pkg::MUL_B_W-1:0]    mul_b;

  logic                            div_done;
  logic [lcwc_pkg::WEIGHT_W-1:0]   div_q;

  lcwc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Calibration point views
  lcwc_pkg::adc_t    px [lcwc_pkg::CAL_POINTS];
  lcwc_pkg::weight_t pw [lcwc_pkg::CAL_POINTS];

  always_comb begin
    for (int i = 0; i < lcwc_pkg::CAL_POINTS; i++) begin
      px[i] = lcwc_pkg::point_raw(cfg.cal_point[i]);
      pw[i] = lcwc_pkg::point_wt(cfg.cal_point[i]);
    end
  end

  // Segment search: first segment that holds the sample
  logic                           seg_hit;
  logic [lcwc_pkg::SEG_IDX_W-1:0] seg_idx;
  logic [lcwc_pkg::SEG_IDX_W-1:0] seg_idx_hi;
  logic                           seg_direct;
  lcwc_pkg::weight_t              seg_weight;

  always_comb begin
    seg_hit = 1'b0;
    seg_idx = '0;
    for (int i = lcwc_pkg::SEGMENTS - 1; i >= 0; i--) begin
      if (raw >= px[i] && raw <= px[i+1]) begin
        seg_hit = 1'b1;
        seg_idx = lcwc_pkg::SEG_IDX_W'(i);
      end
    end
    seg_idx_hi = seg_idx + lcwc_pkg::SEG_IDX_W'(1);
    seg_direct = 1'b1;
    if (raw <= px[0]) begin
      seg_weight = pw[0];
    end else if (raw >= px[lcwc_pkg::CAL_POINTS-1]) begin
      seg_weight = pw[lcwc_pkg::CAL_POINTS-1];
    end else if (!seg_hit) begin
      seg_weight = pw[0];
    end else if (px[seg_idx] == px[seg_idx_hi]) begin
      seg_weight = pw[seg_idx];
    end else begin
      seg_weight = pw[seg_idx];
      seg_direct = 1'b0;
    end
  end

  // Segment operands
  logic [lcwc_pkg::SEG_IDX_W-1:0]   seg_hi;
  logic signed [lcwc_pkg::ADC_BITS:0] num_full, den_full;
  logic signed [lcwc_pkg::DIFF_W-1:0] dw_up, dw_dn;

  assign seg_hi   = seg + lcwc_pkg::SEG_IDX_W'(1);
  assign num_full = (lcwc_pkg::ADC_BITS+1)'(raw) - (lcwc_pkg::ADC_BITS+1)'(px[seg]);
  assign den_full = (lcwc_pkg::ADC_BITS+1)'(px[seg_hi]) - (lcwc_pkg::ADC_BITS+1)'(px[seg]);
  assign dw_up    = lcwc_pkg::DIFF_W'(pw[seg_hi]) - lcwc_pkg::DIFF_W'(pw[seg]);
  assign dw_dn    = lcwc_pkg::DIFF_W'(pw[seg]) - lcwc_pkg::DIFF_W'(pw[seg_hi]);

  // Shared multiplier
  logic [lcwc_pkg::MUL_A_W+lcwc_pkg::MUL_B_W-1:0] mul_full;
  assign mul_full = (lcwc_pkg::MUL_A_W+lcwc_pkg::MUL_B_W)'(mul_a) *
                    (lcwc_pkg::MUL_A_W+lcwc_pkg::MUL_B_W)'(mul_b);

  // Interpolated weight
  logic signed [lcwc_pkg::DIFF_W-1:0] interp;
  assign interp = dw_neg ? (lcwc_pkg::DIFF_W'(weight) - $signed({1'b0, div_q}))
                         : (lcwc_pkg::DIFF_W'(weight) + $signed({1'b0, div_q}));

  // Filter differences
  logic signed [lcwc_pkg::DIFF_W-1:0] sm_up, sm_dn, db_up, db_dn;
  logic [lcwc_pkg::DIFF_W-1:0]        am;
  logic signed [lcwc_pkg::SUM_W-1:0]  sm_sum;

  assign sm_up  = lcwc_pkg::DIFF_W'(tared) - lcwc_pkg::DIFF_W'(smooth_value);
  assign sm_dn  = lcwc_pkg::DIFF_W'(smooth_value) - lcwc_pkg::DIFF_W'(tared);
  assign db_up  = lcwc_pkg::DIFF_W'(smooth_value) - lcwc_pkg::DIFF_W'(shown_value);
  assign db_dn  = lcwc_pkg::DIFF_W'(shown_value) - lcwc_pkg::DIFF_W'(smooth_value);
  assign am     = prod[lcwc_pkg::ALPHA_W +: lcwc_pkg::DIFF_W];
  assign sm_sum = sm_neg ? (lcwc_pkg::SUM_W'(smooth_value) - $signed({1'b0, am}))
                         : (lcwc_pkg::SUM_W'(smooth_value) + $signed({1'b0, am}));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lcwc_pkg::ST_IDLE:     if (cmd.valid) state_next = lcwc_pkg::ST_DECODE;
      lcwc_pkg::ST_DECODE: begin
        state_next = (op_code == lcwc_pkg::OP_SAMPLE) ? lcwc_pkg::ST_SEG
                                                      : lcwc_pkg::ST_FINISH;
      end
      lcwc_pkg::ST_SEG: begin
        state_next = seg_direct ? lcwc_pkg::ST_TARE : lcwc_pkg::ST_PREP;
      end
      lcwc_pkg::ST_PREP:     state_next = lcwc_pkg::ST_CAL_MUL;
      lcwc_pkg::ST_CAL_MUL:  state_next = lcwc_pkg::ST_DIV_GO;
      lcwc_pkg::ST_DIV_GO:   state_next = lcwc_pkg::ST_DIV_WAIT;
      lcwc_pkg::ST_DIV_WAIT: if (div_done) state_next = lcwc_pkg::ST_INTERP;
      lcwc_pkg::ST_INTERP:   state_next = lcwc_pkg::ST_TARE;
      lcwc_pkg::ST_TARE:     state_next = lcwc_pkg::ST_OFFSET;
      lcwc_pkg::ST_OFFSET:   state_next = lcwc_pkg::ST_SM_DIFF;
      lcwc_pkg::ST_SM_DIFF: begin
        state_next = smooth_valid ? lcwc_pkg::ST_SM_ALPHA : lcwc_pkg::ST_DB_DIFF;
      end
      lcwc_pkg::ST_SM_ALPHA: state_next = lcwc_pkg::ST_SM_MUL;
      lcwc_pkg::ST_SM_MUL:   state_next = lcwc_pkg::ST_SM_ADD;
      lcwc_pkg::ST_SM_ADD:   state_next = lcwc_pkg::ST_DB_DIFF;
      lcwc_pkg::ST_DB_DIFF: begin
        state_next = shown_valid ? lcwc_pkg::ST_DB_CMP : lcwc_pkg::ST_FINISH;
      end
      lcwc_pkg::ST_DB_CMP:   state_next = lcwc_pkg::ST_FINISH;
      lcwc_pkg::ST_FINISH:   if (out_load) state_next = lcwc_pkg::ST_IDLE;
      default:               state_next = lcwc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd.ready = (state == lcwc_pkg::ST_IDLE);
    accept    = cmd.ready && cmd.valid;
    div_start = (state == lcwc_pkg::ST_DIV_GO);
    out_load  = (state == lcwc_pkg::ST_FINISH) && (!res_valid || result.ready);
    if (state == lcwc_pkg::ST_SM_MUL) begin
      mul_a = delta;
      mul_b = lcwc_pkg::MUL_B_W'(alpha);
    end else begin
      mul_a = lcwc_pkg::MUL_A_W'(num);
      mul_b = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_code <= cmd.op;
      raw     <= cmd.raw_sample;
    end
    unique case (state) inside
      lcwc_pkg::ST_SEG: begin
        seg    <= seg_idx;
        weight <= seg_weight;
      end
      lcwc_pkg::ST_PREP: begin
        num    <= num_full[lcwc_pkg::ADC_BITS-1:0];
        den    <= den_full[lcwc_pkg::ADC_BITS-1:0];
        dw_neg <= (pw[seg_hi] < pw[seg]);
        mag    <= (pw[seg_hi] < pw[seg]) ? dw_dn[lcwc_pkg::WEIGHT_W-1:0]
                                         : dw_up[lcwc_pkg::WEIGHT_W-1:0];
      end
      lcwc_pkg::ST_CAL_MUL, lcwc_pkg::ST_SM_MUL: begin
        prod <= mul_full[lcwc_pkg::PROD_W-1:0];
      end
      lcwc_pkg::ST_INTERP: begin
        weight <= interp[lcwc_pkg::WEIGHT_W-1:0];
      end
      lcwc_pkg::ST_OFFSET: begin
        tared <= lcwc_pkg::sat_weight(lcwc_pkg::SUM_W'(weight) -
                                      lcwc_pkg::SUM_W'(tare_offset));
      end
      lcwc_pkg::ST_SM_DIFF: begin
        sm_neg <= (tared < smooth_value);
        delta  <= (tared < smooth_value) ? sm_dn : sm_up;
      end
      lcwc_pkg::ST_SM_ALPHA: begin
        alpha <= (delta > lcwc_pkg::DIFF_W'(cfg.big_delta)) ? cfg.alpha_fast
                                                            : cfg.alpha_slow;
      end
      lcwc_pkg::ST_DB_DIFF: begin
        db_mag <= (smooth_value < shown_value) ? db_dn : db_up;
      end
      default: begin
      end
    endcase
  end

  // Architectural state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      tare_pending <= 1'b0;
      tare_offset  <= '0;
      smooth_value <= '0;
      smooth_valid <= 1'b0;
      shown_value  <= '0;
      shown_valid  <= 1'b0;
      fail_streak  <= '0;
    end else begin
      unique case (state)
        lcwc_pkg::ST_DECODE: begin
          case (op_code)
            lcwc_pkg::OP_SAMPLE: begin
              fail_streak <= '0;
            end
            lcwc_pkg::OP_TIMEOUT: begin
              if (fail_streak < lcwc_pkg::FAIL_W'(lcwc_pkg::FAIL_LIMIT)) begin
                fail_streak <= fail_streak + lcwc_pkg::FAIL_W'(1);
              end
            end
            lcwc_pkg::OP_TARE_REQ: begin
              tare_pending <= 1'b1;
            end
            lcwc_pkg::OP_TARE_CLR: begin
              tare_pending <= 1'b0;
              tare_offset  <= '0;
              smooth_value <= '0;
              smooth_valid <= 1'b0;
              shown_value  <= '0;
              shown_valid  <= 1'b0;
            end
            lcwc_pkg::OP_REINIT_DONE: begin
              fail_streak  <= '0;
              smooth_value <= '0;
              smooth_valid <= 1'b0;
              shown_value  <= '0;
              shown_valid  <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        // Pending tare captures the calibrated weight and empties the filters
        lcwc_pkg::ST_TARE: begin
          if (tare_pending) begin
            tare_offset  <= lcwc_pkg::sat_weight(lcwc_pkg::SUM_W'(tare_offset) +
                                                 lcwc_pkg::SUM_W'(weight));
            tare_pending <= 1'b0;
            smooth_value <= '0;
            smooth_valid <= 1'b0;
            shown_value  <= '0;
            shown_valid  <= 1'b0;
          end
        end
        // Empty filter loads the tared weight directly
        lcwc_pkg::ST_SM_DIFF: begin
          if (!smooth_valid) begin
            smooth_value <= tared;
            smooth_valid <= 1'b1;
          end
        end
        lcwc_pkg::ST_SM_ADD: begin
          smooth_value <= lcwc_pkg::sat_weight(sm_sum);
        end
        lcwc_pkg::ST_DB_DIFF: begin
          if (!shown_valid) begin
            shown_value <= smooth_value;
            shown_valid <= 1'b1;
          end
        end
        lcwc_pkg::ST_DB_CMP: begin
          if (db_mag >= lcwc_pkg::DIFF_W'(cfg.deadband)) begin
            shown_value <= smooth_value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_weight_valid <= (op_code == lcwc_pkg::OP_SAMPLE);
      res_display      <= (op_code == lcwc_pkg::OP_SAMPLE) ? shown_value : '0;
      res_reinit       <= (fail_streak >= lcwc_pkg::FAIL_W'(lcwc_pkg::FAIL_LIMIT));
      res_tare         <= tare_offset;
    end
  end

  assign result.valid           = res_valid;
  assign result.weight_valid    = res_weight_valid;
  assign result.display_weight  = res_display;
  assign result.reinit_request  = res_reinit;
  assign result.tare_offset_out = res_tare;

endmodule

FILE: test/lcwc_weight_checker.sv
`timescale 1ns / 100ps

// Watches the command, result and register channels of the weight conditioner,
// predicts each reading from its own copy of the calibration and filter state,
// and compares the readings the block returns in order.
module lcwc_weight_checker (
  input  logic                            clk,
  input  logic                            rst,
  lcwc_cmd_if                             cmd,
  lcwc_res_if                             result,
  input  logic                            cfg_we,
  input  logic [lcwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcwc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              in_flight
);
  import lcwc_pkg::*;

  typedef struct packed {
    logic    weight_valid;
    weight_t display_weight;
    logic    reinit_request;
    weight_t tare_offset;
  } reading_t;

  // Register copy and conditioner state
  cfg_t     cfg_copy;
  logic     tare_pending;
  weight_t  tare_offset;
  weight_t  smooth_value;
  logic     smooth_valid;
  weight_t  shown_value;
  logic     shown_valid;
  int       fail_streak;
  reading_t expected_readings[$];
  int       fails = 0;

  function automatic weight_t sat_grams(longint v);
    if (v > longint'(WEIGHT_MAX)) return WEIGHT_MAX;
    if (v < longint'(WEIGHT_MIN)) return WEIGHT_MIN;
    return weight_t'(v);
  endfunction

  // Four-point piecewise-linear map from ADC counts to grams
  function automatic longint interp_grams(adc_t raw);
    longint x[CAL_POINTS];
    longint w[CAL_POINTS];
    longint r, dw, mag, q;
    r = longint'(raw);
    for (int i = 0; i < CAL_POINTS; i++) begin
      x[i] = longint'(adc_t'(cfg_copy.cal_point[i][ADC_BITS-1:0]));
      w[i] = longint'(weight_t'(cfg_copy.cal_point[i][CAL_W-1:ADC_BITS]));
    end
    // clamp to the end points
    if (r <= x[0]) return w[0];
    if (r >= x[CAL_POINTS-1]) return w[CAL_POINTS-1];
    // first segment holding the sample wins
    for (int i = 0; i < SEGMENTS; i++) begin
      if (r >= x[i] && r <= x[i+1]) begin
        if (x[i+1] == x[i]) return w[i];
        dw  = w[i+1] - w[i];
        mag = (dw < 0) ? -dw : dw;
        q   = ((r - x[i]) * mag) / (x[i+1] - x[i]);
        return (dw < 0) ? w[i] - q : w[i] + q;
      end
    end
    return w[0];
  endfunction

  function automatic void empty_filters();
    smooth_value = '0;
    smooth_valid = 1'b0;
    shown_value  = '0;
    shown_valid  = 1'b0;
  endfunction

  // Exponential average, fast alpha on big steps
  function automatic weight_t ema_update(weight_t w);
    longint             diff, delta, am;
    logic [ALPHA_W-1:0] alpha;
    if (!smooth_valid) begin
      smooth_value = w;
      smooth_valid = 1'b1;
      return w;
    end
    diff  = longint'(w) - longint'(smooth_value);
    delta = (diff < 0) ? -diff : diff;
    alpha = (delta > longint'(cfg_copy.big_delta)) ? cfg_copy.alpha_fast : cfg_copy.alpha_slow;
    am    = (delta * longint'(alpha)) >> ALPHA_W;
    smooth_value = sat_grams(longint'(smooth_value) + ((diff < 0) ? -am : am));
    return smooth_value;
  endfunction

  // Hold the shown value until the change reaches the deadband
  function automatic weight_t deadband_hold(weight_t s);
    longint diff, mag;
    if (!shown_valid) begin
      shown_value = s;
      shown_valid = 1'b1;
      return s;
    end
    diff = longint'(s) - longint'(shown_value);
    mag  = (diff < 0) ? -diff : diff;
    if (mag >= longint'(cfg_copy.deadband)) shown_value = s;
    return shown_value;
  endfunction

  function automatic reading_t predict_reading(logic [OP_W-1:0] op, adc_t raw);
    reading_t rd;
    longint   grams;
    weight_t  tared;
    rd.weight_valid   = 1'b0;
    rd.display_weight = '0;
    case (op)
      OP_SAMPLE: begin
        grams       = interp_grams(raw);
        fail_streak = 0;
        // pending tare captures this weight
        if (tare_pending) begin
          tare_offset  = sat_grams(longint'(tare_offset) + grams);
          tare_pending = 1'b0;
          empty_filters();
        end
        tared             = sat_grams(grams - longint'(tare_offset));
        rd.display_weight = deadband_hold(ema_update(tared));
        rd.weight_valid   = 1'b1;
      end
      OP_TIMEOUT: begin
        if (fail_streak < FAIL_LIMIT) fail_streak++;
      end
      OP_TARE_REQ: begin
        tare_pending = 1'b1;
      end
      OP_TARE_CLR: begin
        tare_pending = 1'b0;
        tare_offset  = '0;
        empty_filters();
      end
      OP_REINIT_DONE: begin
        fail_streak = 0;
        empty_filters();
      end
      default: begin
      end
    endcase
    rd.reinit_request = (fail_streak >= FAIL_LIMIT);
    rd.tare_offset    = tare_offset;
    return rd;
  endfunction

  task automatic check_field(string field, logic signed [WEIGHT_W-1:0] want,
                             logic signed [WEIGHT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fails++;
    end
  endtask

  // Track registers, check returned readings, predict accepted items
  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      cfg_copy            = '0;
      cfg_copy.alpha_fast = ALPHA_FAST_RST;
      cfg_copy.alpha_slow = ALPHA_SLOW_RST;
      cfg_copy.big_delta  = BIG_DELTA_RST;
      cfg_copy.deadband   = DEADBAND_RST;
      tare_pending        = 1'b0;
      tare_offset         = '0;
      fail_streak         = 0;
      empty_filters();
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CAL_0:      cfg_copy.cal_point[0] = cfg_wdata;
          REG_CAL_1:      cfg_copy.cal_point[1] = cfg_wdata;
          REG_CAL_2:      cfg_copy.cal_point[2] = cfg_wdata;
          REG_CAL_3:      cfg_copy.cal_point[3] = cfg_wdata;
          REG_ALPHA_FAST: cfg_copy.alpha_fast   = cfg_wdata[ALPHA_W-1:0];
          REG_ALPHA_SLOW: cfg_copy.alpha_slow   = cfg_wdata[ALPHA_W-1:0];
          REG_BIG_DELTA:  cfg_copy.big_delta    = cfg_wdata[THR_W-1:0];
          REG_DEADBAND:   cfg_copy.deadband     = cfg_wdata[THR_W-1:0];
          default: begin
          end
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual weight %0d", $time,
                   result.display_weight);
          fails++;
        end else begin
          want = expected_readings.pop_front();
          check_field("weight_valid", want.weight_valid, result.weight_valid);
          check_field("display_weight", want.display_weight, result.display_weight);
          check_field("reinit_request", want.reinit_request, result.reinit_request);
          check_field("tare_offset_out", want.tare_offset, result.tare_offset_out);
        end
      end
      if (cmd.valid && cmd.ready)
        expected_readings.push_back(predict_reading(cmd.op, cmd.raw_sample));
    end
    in_flight  <= expected_readings.size();
    fail_count <= fails;
  end

endmodule

FILE: test/tb_load_cell_weight_conditioner.sv
`timescale 1ns / 100ps

module tb_load_cell_weight_conditioner;
  import lcwc_pkg::*;

  localparam int CYCLE_LIMIT      = 800000;
  localparam int SETTLE_CYCLES    = 60;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 9;
  localparam int PHASE_ITEMS      = 100;

  // Op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    in_flight;

  logic calm_tail     = 1'b0;  // no idling on either side
  logic bursty        = 1'b1;  // sender gaps allowed in this phase
  int   long_hold_req = 0;
  int   level_raw     = 0;

  lcwc_cmd_if cmd_ch();
  lcwc_res_if res_ch();

  load_cell_weight_conditioner i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcwc_weight_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .result     (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [CAL_W-1:0] cal_entry(int x, int w);
    return {w, x[ADC_BITS-1:0]};
  endfunction

  function automatic logic [ALPHA_W-1:0] random_alpha();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  // Random calibration: mostly sorted points, some unsorted or duplicated
  function automatic cfg_t random_cfg();
    cfg_t c;
    int   xs[CAL_POINTS];
    int   t, span, wt;
    logic wide;
    c    = '0;
    wide = ($urandom_range(0, 3) == 0);
    span = 1 << $urandom_range(12, 28);
    for (int i = 0; i < CAL_POINTS; i++) xs[i] = $signed($urandom) >>> 8;
    if ($urandom_range(0, 7) != 0) begin
      for (int i = 0; i < CAL_POINTS - 1; i++) begin
        for (int j = 0; j < CAL_POINTS - 1 - i; j++) begin
          if (xs[j] > xs[j+1]) begin
            t       = xs[j];
            xs[j]   = xs[j+1];
            xs[j+1] = t;
          end
        end
      end
    end
    if ($urandom_range(0, 7) == 0) xs[2] = xs[1];
    for (int i = 0; i < CAL_POINTS; i++) begin
      wt = wide ? int'($urandom) : int'($urandom_range(0, 2 * span)) - span;
      c.cal_point[i] = cal_entry(xs[i], wt);
    end
    c.alpha_fast = random_alpha();
    c.alpha_slow = random_alpha();
    case ($urandom_range(0, 7))
      0:       c.big_delta = '0;
      1:       c.big_delta = '1;
      default: c.big_delta = THR_W'($urandom_range(0, 1 << 18));
    endcase
    case ($urandom_range(0, 9))
      0:       c.deadband = '0;
      1:       c.deadband = '1;
      default: c.deadband = THR_W'($urandom_range(0, 4096));
    endcase
    return c;
  endfunction

  // Samples drift around a level, with jumps, points and wild values
  function automatic int pick_raw(cfg_t c);
    int sel, idx;
    sel = $urandom_range(0, 15);
    if (sel == 0) return int'($urandom);
    if (sel == 1) begin
      idx = $urandom_range(0, CAL_POINTS - 1);
      return int'(adc_t'(c.cal_point[idx][ADC_BITS-1:0])) + int'($urandom_range(0, 6)) - 3;
    end
    if (sel == 2) level_raw = $signed($urandom) >>> 8;
    level_raw = level_raw + int'($urandom_range(0, 2000)) - 1000;
    return level_raw;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return OP_SAMPLE;
    if (sel < 80) return OP_TIMEOUT;
    if (sel < 87) return OP_TARE_REQ;
    if (sel < 91) return OP_TARE_CLR;
    if (sel < 95) return OP_REINIT_DONE;
    return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  task automatic send_cmd(logic [OP_W-1:0] op, int raw);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.op         <= op;
    cmd_ch.raw_sample <= adc_t'(raw);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic idle_cmd(int n);
    cmd_ch.valid      <= 1'b0;
    cmd_ch.op         <= OP_W'($urandom);
    cmd_ch.raw_sample <= adc_t'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Item with an occasional gap ahead of it
  task automatic offer(logic [OP_W-1:0] op, int raw);
    if (!calm_tail && bursty && $urandom_range(0, 4) == 0) idle_cmd($urandom_range(1, 15));
    send_cmd(op, raw);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(REG_CAL_0, c.cal_point[0]);
    write_reg(REG_CAL_1, c.cal_point[1]);
    write_reg(REG_CAL_2, c.cal_point[2]);
    write_reg(REG_CAL_3, c.cal_point[3]);
    write_reg(REG_ALPHA_FAST, CFG_DATA_W'(c.alpha_fast));
    write_reg(REG_ALPHA_SLOW, CFG_DATA_W'(c.alpha_slow));
    write_reg(REG_BIG_DELTA, CFG_DATA_W'(c.big_delta));
    write_reg(REG_DEADBAND, CFG_DATA_W'(c.deadband));
    cfg_we <= 1'b0;
  endtask

  // Wait until every reading is back and the block has gone quiet
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: short stall bursts, quiet stretches, one long hold-off
  initial begin
    int hold_left, quiet_left, holds_done;
    hold_left    = 0;
    quiet_left   = 0;
    holds_done   = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (holds_done < long_hold_req) begin
        holds_done++;
        hold_left = LONG_HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (calm_tail || quiet_left > 0) begin
        if (quiet_left > 0) quiet_left--;
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        quiet_left = $urandom_range(40, 200);
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 15) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("** load_cell_weight_conditioner: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    cfg_t            s;
    int              n, reps;
    logic [OP_W-1:0] op;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.op         <= OP_SAMPLE;
    cmd_ch.raw_sample <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_CAL_0;
    cfg_wdata         <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: timeout streak saturates, a sample clears it
    repeat (4) offer(OP_TIMEOUT, 0);
    offer(OP_SAMPLE, 1234);
    settle();

    // Sorted points with a falling middle segment
    s              = '0;
    s.cal_point[0] = cal_entry(-6000000, -2048000);
    s.cal_point[1] = cal_entry(-1000000, 512000);
    s.cal_point[2] = cal_entry(2000000, 307200);
    s.cal_point[3] = cal_entry(7000000, 5120000);
    s.alpha_fast   = ALPHA_FAST_RST;
    s.alpha_slow   = ALPHA_SLOW_RST;
    s.big_delta    = BIG_DELTA_RST;
    s.deadband     = DEADBAND_RST;
    apply_cfg(s);
    offer(OP_SAMPLE, -8388608);
    offer(OP_SAMPLE, 8388607);
    offer(OP_SAMPLE, -6000000);
    offer(OP_SAMPLE, 7000000);
    offer(OP_SAMPLE, -1000000);
    offer(OP_SAMPLE, 500000);
    offer(OP_SAMPLE, -3000000);
    offer(OP_TARE_REQ, 0);
    offer(OP_SAMPLE, 4000000);
    offer(OP_SAMPLE, 4000100);
    offer(OP_TARE_CLR, 0);
    offer(OP_SPARE_LO, -1);
    offer(OP_SPARE_HI, 8388607);
    offer(OP_REINIT_DONE, 0);
    settle();

    // Full-scale weights: tare and offset sums saturate
    s              = '0;
    s.cal_point[0] = cal_entry(-8388608, int'(WEIGHT_MIN));
    s.cal_point[1] = cal_entry(-1, -1);
    s.cal_point[2] = cal_entry(0, 0);
    s.cal_point[3] = cal_entry(8388607, int'(WEIGHT_MAX));
    s.alpha_fast   = '1;
    s.alpha_slow   = '0;
    s.big_delta    = '0;
    s.deadband     = '0;
    apply_cfg(s);
    offer(OP_TARE_REQ, 0);
    offer(OP_SAMPLE, 8388607);
    offer(OP_TARE_REQ, 0);
    offer(OP_SAMPLE, 8388607);
    offer(OP_SAMPLE, -8388608);
    settle();

    // Unsorted points and a duplicated point
    s              = '0;
    s.cal_point[0] = cal_entry(1000, 10240);
    s.cal_point[1] = cal_entry(-5000, -20480);
    s.cal_point[2] = cal_entry(3000, 3000);
    s.cal_point[3] = cal_entry(3000, 90000);
    s.alpha_fast   = '0;
    s.alpha_slow   = '1;
    s.big_delta    = '1;
    s.deadband     = '1;
    apply_cfg(s);
    offer(OP_SAMPLE, 500);
    offer(OP_SAMPLE, 2000);
    offer(OP_SAMPLE, 3000);

    // Random phases, each with fresh settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      s = random_cfg();
      if (ph == 0) begin
        s.alpha_fast = '0;
        s.alpha_slow = '1;
        s.big_delta  = '1;
        s.deadband   = '0;
      end else if (ph == 1) begin
        s.alpha_fast = '1;
        s.alpha_slow = '0;
        s.big_delta  = '0;
      end
      apply_cfg(s);
      bursty = ($urandom_range(0, 3) != 0);
      // sender keeps pushing while the result side holds off
      if (ph == 2) begin
        bursty = 1'b0;
        long_hold_req <= long_hold_req + 1;
      end
      if (ph == RANDOM_PHASES - 1) calm_tail <= 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        op   = pick_op();
        reps = (op == OP_TIMEOUT && $urandom_range(0, 1) == 1) ? $urandom_range(2, 4) : 1;
        repeat (reps) begin
          offer(op, pick_raw(s));
          n++;
        end
      end
    end

    settle();
    if (fail_count == 0 && in_flight == 0) begin
      $display("** load_cell_weight_conditioner: PASSED **");
    end else begin
      $display("** load_cell_weight_conditioner: FAILED **");
    end
    $finish;
  end

endmodule

FILE: load_cell_weight_conditioner.f
design/lcwc_pkg.sv
design/lcwc_ifs.sv
design/lcwc_cfg.sv
design/lcwc_div.sv
design/load_cell_weight_conditioner.sv
test/lcwc_weight_checker.sv
test/tb_load_cell_weight_conditioner.sv
